/* hw/rtl/bdpr_pkg.sv */
package bdpr_pkg;

  // list geometry
  localparam int CAPACITY  = 16;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int VAL_W     = 32;
  localparam int POS_W     = 8;
  localparam int OUT_IDX_W = 6;

  typedef enum logic [1:0] {
    REQ_FRONT  = 2'd0,
    REQ_BACK   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // write side of the entry store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } wr_req_t;

endpackage

/* hw/rtl/bdpr_ram.sv */
module bdpr_ram (
  input  logic                      clk,
  input  bdpr_pkg::wr_req_t         wr,
  input  logic [bdpr_pkg::IDX_W-1:0] rd_addr,
  output logic [bdpr_pkg::VAL_W-1:0] rd_data
);
  import bdpr_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/bounded_deque_positional_remove_top.sv */
// Channel  | Ports                                       | Transfer
// ---------+---------------------------------------------+----------------------------
// input    | in_req_type, in_value, in_position          | start high, busy low
// result   | out_status, out_item_value, out_item_index, | out_valid high, one cycle,
//          | out_last_item                               | no back-pressure
//
// Every step goes through the store (one registered read and one write a cycle)
// and the shared index stepper; each entry moved or reported takes a read state
// followed by a write or report state.
// Reset (rst_n low, synchronous) empties the list; store contents are not cleared.
// The receiver cannot stall: each result shows for exactly one cycle.
module bounded_deque_positional_remove_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_req_type,
  input  logic signed [bdpr_pkg::VAL_W-1:0] in_value,
  input  logic [bdpr_pkg::POS_W-1:0]    in_position,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic signed [bdpr_pkg::VAL_W-1:0] out_item_value,
  output logic [bdpr_pkg::OUT_IDX_W-1:0] out_item_index,
  output logic                          out_last_item
);
  import bdpr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SH_RD,   // front insert: fetch entry ptr-1
    S_SH_WR,   // front insert: move it up to ptr
    S_INS_WR,  // write the new value
    S_RM_RD,   // remove: fetch victim
    S_RM_CAP,  // remove: capture victim
    S_MV_RD,   // remove: fetch entry ptr+1
    S_MV_WR,   // remove: move it down to ptr
    S_RD_RD,   // read-all: fetch entry ptr
    S_RD_OUT   // read-all: report it
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] ptr_r;
  logic [IDX_W-1:0] wa_r;
  logic [IDX_W-1:0] idx_r;
  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] removed_r;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [VAL_W-1:0] out_value_r;
  logic [OUT_IDX_W-1:0] out_index_r;
  logic             out_last_r;

  wr_req_t          ram_wr;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [VAL_W-1:0] ram_rd_data;

  // shared index stepper: ptr - 1 while shifting up, ptr + 1 otherwise
  logic             step_dec;
  logic [CNT_W:0]   step;
  logic [CNT_W:0]   count_x;
  logic [CNT_W:0]   step_inc;
  logic             accept;
  logic             pos_ok;
  logic [IDX_W-1:0] rm_idx;

  assign step_dec = (state_r == S_SH_RD) || (state_r == S_SH_WR);
  assign step     = {1'b0, ptr_r} + (step_dec ? {(CNT_W+1){1'b1}} : (CNT_W+1)'(1));
  assign step_inc = step + (CNT_W+1)'(1);
  assign count_x  = {1'b0, count_r};

  assign accept = start && !busy;
  assign pos_ok = in_position < POS_W'(count_r);
  assign rm_idx = pos_ok ? in_position[IDX_W-1:0] : '0;

  bdpr_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // store port steering
  always_comb begin
    ram_wr      = '0;
    ram_rd_addr = ptr_r[IDX_W-1:0];
    case (state_r)
      S_SH_RD: begin
        ram_rd_addr = step[IDX_W-1:0];
      end
      S_SH_WR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = ptr_r[IDX_W-1:0];
        ram_wr.data = ram_rd_data;
      end
      S_INS_WR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = wa_r;
        ram_wr.data = val_r;
      end
      S_MV_RD: begin
        ram_rd_addr = step[IDX_W-1:0];
      end
      S_MV_WR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = ptr_r[IDX_W-1:0];
        ram_wr.data = ram_rd_data;
      end
      default: begin
        ram_rd_addr = ptr_r[IDX_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            val_r <= in_value;
            case (req_t'(in_req_type))
              REQ_FRONT, REQ_BACK: begin
                if (count_r == CNT_W'(CAPACITY)) begin
                  // full: drop the value, answer at once
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_FULL;
                  out_value_r  <= '0;
                  out_index_r  <= '0;
                  out_last_r   <= 1'b1;
                end else if (req_t'(in_req_type) == REQ_BACK) begin
                  wa_r    <= count_r[IDX_W-1:0];
                  state_r <= S_INS_WR;
                end else begin
                  wa_r    <= '0;
                  ptr_r   <= count_r;
                  state_r <= (count_r == '0) ? S_INS_WR : S_SH_RD;
                end
              end
              default: begin
                if (count_r == '0) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_EMPTY;
                  out_value_r  <= '0;
                  out_index_r  <= '0;
                  out_last_r   <= 1'b1;
                end else if (req_t'(in_req_type) == REQ_REMOVE) begin
                  // out-of-range position wraps to the head
                  idx_r   <= rm_idx;
                  ptr_r   <= CNT_W'(rm_idx);
                  state_r <= S_RM_RD;
                end else begin
                  ptr_r   <= '0;
                  state_r <= S_RD_RD;
                end
              end
            endcase
          end
        end
        S_SH_RD: begin
          state_r <= S_SH_WR;
        end
        S_SH_WR: begin
          ptr_r   <= step[CNT_W-1:0];
          state_r <= (step == '0) ? S_INS_WR : S_SH_RD;
        end
        S_INS_WR: begin
          count_r      <= count_r + CNT_W'(1);
          out_valid_r  <= 1'b1;
          out_status_r <= ST_OK;
          out_value_r  <= '0;
          out_index_r  <= '0;
          out_last_r   <= 1'b1;
          state_r      <= S_IDLE;
        end
        S_RM_RD: begin
          state_r <= S_RM_CAP;
        end
        S_RM_CAP: begin
          removed_r <= ram_rd_data;
          if (step < count_x) begin
            state_r <= S_MV_RD;
          end else begin
            // victim was the tail: nothing to close up
            count_r      <= count_r - CNT_W'(1);
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            out_value_r  <= ram_rd_data;
            out_index_r  <= OUT_IDX_W'(idx_r);
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_MV_RD: begin
          state_r <= S_MV_WR;
        end
        S_MV_WR: begin
          ptr_r <= step[CNT_W-1:0];
          if (step_inc < count_x) begin
            state_r <= S_MV_RD;
          end else begin
            count_r      <= count_r - CNT_W'(1);
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            out_value_r  <= removed_r;
            out_index_r  <= OUT_IDX_W'(idx_r);
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_RD_RD: begin
          state_r <= S_RD_OUT;
        end
        S_RD_OUT: begin
          out_valid_r  <= 1'b1;
          out_status_r <= ST_OK;
          out_value_r  <= ram_rd_data;
          out_index_r  <= OUT_IDX_W'(ptr_r);
          out_last_r   <= (step == count_x);
          ptr_r        <= step[CNT_W-1:0];
          state_r      <= (step == count_x) ? S_IDLE : S_RD_RD;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_item_value = out_value_r;
  assign out_item_index = out_index_r;
  assign out_last_item  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr.en |-> (state_r != S_IDLE))
    else $error("store written while idle");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && count_r == CNT_W'(CAPACITY) &&
     (in_req_type == REQ_FRONT || in_req_type == REQ_BACK))
    |=> (out_valid && out_status == ST_FULL && $stable(count_r)))
    else $error("insert on full list not dropped");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_item) |-> busy)
    else $error("non-final result with sequencer idle");

endmodule
